/* hdl/sdh_pkg.sv */
package sdh_pkg;

  // Field widths fixed by the item formats
  localparam int POS_W       = 32;
  localparam int INV_W       = 24;
  localparam int BINS_W      = 13;
  localparam int BIN_W       = 12;
  localparam int SPEC_W      = 2;
  localparam int OUT_CNT_W   = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 112;

  // Products: Q16.16 x Q8.16 signed, z side has one extra difference bit
  localparam int PX_W   = POS_W + INV_W + 1;
  localparam int PZ_W   = POS_W + INV_W + 2;
  localparam int FRAC_W = 32;
  // Flattened bin: (x_bins-1)*z_bins + (z_bins-1) fits in 2*BINS_W bits
  localparam int FLAT_W = 2 * BINS_W;

  // Register reset values
  localparam logic [INV_W-1:0]  INV_BIN_RST = 24'd1310720;
  localparam logic [POS_W-1:0]  Z_BASE_RST  = 32'd0;
  localparam logic [BINS_W-1:0] BINS_RST    = 13'd64;

  // Item kind carried in in_tuser
  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Species codes
  localparam logic [SPEC_W-1:0] SP_SOLVENT = 2'd0;
  localparam logic [SPEC_W-1:0] SP_POLYMER = 2'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_BIN_X = 3'd0,
    CFG_INV_BIN_Z = 3'd1,
    CFG_Z_BASE    = 3'd2,
    CFG_X_BINS    = 3'd3,
    CFG_Z_BINS    = 3'd4
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;   // write zero at the sweep address, advance sweep
    logic load;  // capture an input transfer
    logic mul;   // register the two position products
    logic idx;   // form the flattened bin and grid check
    logic addr;  // capacity check and memory read
    logic upd;   // write back counts and load the output register
  } sdh_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;  // sweep is at the last entry
    logic out_busy;  // output register holds a result not taken this cycle
  } sdh_sts_t;

endpackage

/* hdl/sdh_ctrl.sv */
module sdh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sdh_pkg::sdh_sts_t sts,
  output sdh_pkg::sdh_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_IDX   = 6'b001000,
    ST_ADDR  = 6'b010000,
    ST_UPD   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register can take the result
        if (!sts.out_busy) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/sdh_dp.sv */
module sdh_dp #(
  parameter int BIN_CAPACITY = 4096,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sdh_pkg::sdh_cmd_t                  cmd,
  output sdh_pkg::sdh_sts_t                  sts,
  input  logic [sdh_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  logic                               cfg_valid,
  input  logic [sdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdh_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [sdh_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);

  localparam int AW    = $clog2(BIN_CAPACITY);
  localparam int ROW_W = 3 * COUNT_WIDTH;
  localparam logic [sdh_pkg::FLAT_W-1:0] CAP = sdh_pkg::FLAT_W'(BIN_CAPACITY);

  // Configuration registers
  logic [sdh_pkg::INV_W-1:0]  inv_x_r, inv_z_r;
  logic [sdh_pkg::POS_W-1:0]  zbase_r;
  logic [sdh_pkg::BINS_W-1:0] xbins_r, zbins_r;

  // Captured item
  logic                       op_r;
  logic [sdh_pkg::POS_W-1:0]  x_r, z_r;
  logic [sdh_pkg::SPEC_W-1:0] sp_r;
  logic [sdh_pkg::BIN_W-1:0]  rbin_r;

  // Pipeline registers
  logic signed [sdh_pkg::PX_W-1:0] px_r, px_nxt;
  logic signed [sdh_pkg::PZ_W-1:0] pz_r, pz_nxt;
  logic signed [sdh_pkg::POS_W:0]  zdiff;
  logic [sdh_pkg::FLAT_W-1:0]      flat_r, flat_nxt;
  logic                            drop_r, drop_nxt;
  logic                            drop_f_r;
  logic [ROW_W-1:0]                rdata_r;
  logic [AW-1:0]                   clr_addr_r;

  // Output register
  logic                            out_tvalid_r;
  logic [sdh_pkg::OUT_CNT_W-1:0]   o_tot_r, o_sol_r, o_pol_r;
  logic [sdh_pkg::BIN_W-1:0]       o_bin_r;
  logic                            o_drop_r;

  // Count memory: one row holds total, solvent and polymer
  logic [ROW_W-1:0] mem [BIN_CAPACITY];

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [sdh_pkg::OUT_CNT_W-1:0] clip32(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] e;
    e = 64'(c);
    return (|e[63:32]) ? '1 : e[31:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r <= sdh_pkg::INV_BIN_RST;
      inv_z_r <= sdh_pkg::INV_BIN_RST;
      zbase_r <= sdh_pkg::Z_BASE_RST;
      xbins_r <= sdh_pkg::BINS_RST;
      zbins_r <= sdh_pkg::BINS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdh_pkg::CFG_INV_BIN_X: inv_x_r <= cfg_data[sdh_pkg::INV_W-1:0];
        sdh_pkg::CFG_INV_BIN_Z: inv_z_r <= cfg_data[sdh_pkg::INV_W-1:0];
        sdh_pkg::CFG_Z_BASE:    zbase_r <= cfg_data[sdh_pkg::POS_W-1:0];
        sdh_pkg::CFG_X_BINS:    xbins_r <= cfg_data[sdh_pkg::BINS_W-1:0];
        sdh_pkg::CFG_Z_BINS:    zbins_r <= cfg_data[sdh_pkg::BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tuser;
      x_r    <= in_tdata[31:0];
      z_r    <= in_tdata[63:32];
      sp_r   <= in_tdata[65:64];
      rbin_r <= in_tdata[77:66];
    end
  end

  // Stage 1: position times reciprocal, Q25.32 (x) and Q26.32 (z) results
  assign zdiff  = $signed({z_r[31], z_r}) - $signed({zbase_r[31], zbase_r});
  assign px_nxt = $signed(x_r) * $signed({1'b0, inv_x_r});
  assign pz_nxt = zdiff * $signed({1'b0, inv_z_r});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      px_r <= px_nxt;
      pz_r <= pz_nxt;
    end
  end

  // Stage 2: floor to bin indexes, grid check, flatten
  logic [sdh_pkg::PX_W-sdh_pkg::FRAC_W-2:0] xb;
  logic [sdh_pkg::PZ_W-sdh_pkg::FRAC_W-2:0] zb;
  logic                                     neg, xb_oor, zb_oor;
  logic [sdh_pkg::FLAT_W-1:0]               flat_prod;

  assign neg    = px_r[sdh_pkg::PX_W-1] | pz_r[sdh_pkg::PZ_W-1];
  assign xb     = px_r[sdh_pkg::PX_W-2:sdh_pkg::FRAC_W];
  assign zb     = pz_r[sdh_pkg::PZ_W-2:sdh_pkg::FRAC_W];
  assign xb_oor = xb >= $bits(xb)'(xbins_r);
  assign zb_oor = zb >= $bits(zb)'(zbins_r);
  assign flat_prod = sdh_pkg::FLAT_W'(xb[sdh_pkg::BINS_W-1:0])
                   * sdh_pkg::FLAT_W'(zbins_r)
                   + sdh_pkg::FLAT_W'(zb[sdh_pkg::BINS_W-1:0]);
  assign flat_nxt = (op_r == sdh_pkg::CMD_READ) ? sdh_pkg::FLAT_W'(rbin_r) : flat_prod;
  assign drop_nxt = (op_r == sdh_pkg::CMD_ACC) & (neg | xb_oor | zb_oor);

  always_ff @(posedge clk) begin
    if (cmd.idx) begin
      flat_r <= flat_nxt;
      drop_r <= drop_nxt;
    end
  end

  // Stage 3: capacity check and row read
  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      drop_f_r <= drop_r | (flat_r >= CAP);
    end
  end

  // Stage 4: saturating increment and write back
  logic [COUNT_WIDTH-1:0] tot_old, sol_old, pol_old;
  logic [COUNT_WIDTH-1:0] tot_new, sol_new, pol_new;
  logic                   hit, inc_sol, inc_pol;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [ROW_W-1:0]       mem_wdata;

  assign tot_old = rdata_r[COUNT_WIDTH-1:0];
  assign sol_old = rdata_r[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign pol_old = rdata_r[3*COUNT_WIDTH-1:2*COUNT_WIDTH];
  assign hit     = (op_r == sdh_pkg::CMD_ACC) & ~drop_f_r;
  assign inc_sol = hit & (sp_r == sdh_pkg::SP_SOLVENT);
  assign inc_pol = hit & (sp_r == sdh_pkg::SP_POLYMER);
  assign tot_new = (inc_sol | inc_pol) ? sat_inc(tot_old) : tot_old;
  assign sol_new = inc_sol ? sat_inc(sol_old) : sol_old;
  assign pol_new = inc_pol ? sat_inc(pol_old) : pol_old;

  // Clearing sweep shares the write port
  assign mem_we    = cmd.clr | (cmd.upd & (inc_sol | inc_pol));
  assign mem_waddr = cmd.clr ? clr_addr_r : flat_r[AW-1:0];
  assign mem_wdata = cmd.clr ? '0 : {pol_new, sol_new, tot_new};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.addr) begin
      rdata_r <= mem[flat_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.clr_done = (clr_addr_r == AW'(BIN_CAPACITY - 1));
  assign sts.out_busy = out_tvalid_r & ~out_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      o_tot_r  <= drop_f_r ? '0 : clip32(tot_new);
      o_sol_r  <= drop_f_r ? '0 : clip32(sol_new);
      o_pol_r  <= drop_f_r ? '0 : clip32(pol_new);
      // a dropped particle reports bin zero, a bad read keeps its index
      o_bin_r  <= ((op_r == sdh_pkg::CMD_ACC) & drop_f_r) ? '0
                : flat_r[sdh_pkg::BIN_W-1:0];
      o_drop_r <= drop_f_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, o_bin_r, o_pol_r, o_sol_r, o_tot_r};
  assign out_tuser  = o_drop_r;

endmodule

/* hdl/species_density_histogram_2d_unit.sv */
// Two-dimensional x,z particle histogram kept per species.
// Input channel (in_*): one transfer is one item. in_tuser selects the kind:
// accumulate a particle at (x_pos, z_pos) of a species, or read one bin.
// Output channel (out_*): exactly one result per item, in order: the three
// counts of the bin, its flattened index, and a dropped flag in out_tuser.
// Configuration (cfg_*): register index and data, always ready; write only
// while no item is in flight.
// Sequence: each item passes through capture, multiply, bin flatten multiply,
// count memory read, then write back, with one item in flight; the next input
// transfer is accepted only after write back, and the result is loaded into
// the output register at write back.
// Reset: configuration returns to its defaults and a clearing sweep writes
// zero to every count row, one row a cycle; in_tready
// stays low during the sweep.
// Stall: a result waits in the output register; the next item is accepted
// and processed meanwhile, and holds in its write-back step until the
// waiting result is transferred.
module species_density_histogram_2d_unit #(
  parameter int BIN_CAPACITY = 4096,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] x_pos, [63:32] z_pos, [65:64] species, [77:66] read_bin, [79:78] zero
  input  logic [sdh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                            in_tuser,
  // result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] count_total, [63:32] count_solvent, [95:64] count_polymer,
  // [107:96] bin_out, [111:108] zero
  output logic [sdh_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] dropped
  output logic                            out_tuser,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sdh_pkg::sdh_cmd_t cmd;
  sdh_pkg::sdh_sts_t sts;

  assign cfg_ready = 1'b1;

  sdh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdh_dp #(
    .BIN_CAPACITY (BIN_CAPACITY),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Input is held off for the clearing sweep after reset
  a_clear_blocks_input: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_tready)
    else $error("input ready right after reset");

  // One item in flight: no transfer in the cycle after an input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in flight");

  // A result is valid on the output after each accepted input transfer
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##5 out_tvalid)
    else $error("no result after accepted item");

  // The controller never writes back while the output register is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> !sts.out_busy)
    else $error("output register overwritten");

endmodule
